// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== sv/arc_pkg.sv =====
package arc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int DIG_AW     = $clog2(MAX_DIGITS);
  localparam int DIV_CW     = $clog2(VALUE_BITS);

  localparam logic [7:0] DIGIT_OFFSET        = 8'd48;
  localparam logic [7:0] LETTER_UPPER_OFFSET = 8'd55;
  localparam logic [7:0] LETTER_LOWER_OFFSET = 8'd87;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  typedef enum logic {
    REG_SOURCE_BASE = 1'b0,
    REG_TARGET_BASE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    base_t source_base;
    base_t target_base;
  } cfg_t;

  typedef struct packed {
    logic  start;
    base_t radix_sel;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [3:0] remainder;
  } div_rsp_t;

  function automatic logic [4:0] radix_of(base_t b);
    logic [4:0] r;
    case (b)
      BASE_BIN: r = 5'd2;
      BASE_OCT: r = 5'd8;
      BASE_DEC: r = 5'd10;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd16;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/arc_cfg.sv =====
module arc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output arc_pkg::cfg_t cfg
);
  import arc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t sel;
  logic     wr_en;

  // Registers sit on 4-byte boundaries, so bit 2 picks the register.
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (sel)
        REG_SOURCE_BASE: cfg_nxt.source_base = base_t'(pwdata[1:0]);
        REG_TARGET_BASE: cfg_nxt.target_base = base_t'(pwdata[1:0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_base <= BASE_BIN;
      cfg_r.target_base <= BASE_DEC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (sel)
      REG_SOURCE_BASE: prdata = {30'd0, cfg_r.source_base};
      REG_TARGET_BASE: prdata = {30'd0, cfg_r.target_base};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/arc_div.sv =====
module arc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  arc_pkg::div_req_t                  req,
  input  logic [arc_pkg::VALUE_BITS-1:0]     dividend,
  output arc_pkg::div_rsp_t                  rsp,
  output logic [arc_pkg::VALUE_BITS-1:0]     quotient
);
  import arc_pkg::*;

  logic [VALUE_BITS-1:0] quo_r;
  logic [3:0]            rem_r;
  logic [4:0]            radix_r;
  logic [DIV_CW-1:0]     cnt_r;
  logic                  running_r;
  logic                  done_r;

  logic [4:0] rem_s;
  logic [4:0] rem_diff;
  logic       ge;
  logic       last_step;

  // Restoring division, one quotient bit per cycle. The partial remainder
  // stays below the radix, so four bits hold it.
  assign rem_s     = {rem_r, quo_r[VALUE_BITS-1]};
  assign ge        = (rem_s >= radix_r);
  assign rem_diff  = rem_s - radix_r;
  assign last_step = (cnt_r == DIV_CW'(VALUE_BITS - 1));

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r   <= dividend;
      rem_r   <= 4'd0;
      radix_r <= radix_of(req.radix_sel);
    end else if (running_r) begin
      quo_r <= {quo_r[VALUE_BITS-2:0], ge};
      rem_r <= ge ? rem_diff[3:0] : rem_s[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= running_r && last_step;
      if (req.start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          running_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;
  assign quotient      = quo_r;

endmodule

// ===== sv/arc_ctrl.sv =====
module arc_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  arc_pkg::cfg_t                  cfg,
  input  logic                           start,
  input  logic [7:0]                     in_char_code,
  input  logic                           in_is_final,
  output logic                           busy,
  output logic                           out_valid,
  output logic [7:0]                     out_digit_char,
  output logic                           out_digit_last,
  output arc_pkg::div_req_t              div_req,
  output logic [arc_pkg::VALUE_BITS-1:0] dividend,
  input  arc_pkg::div_rsp_t              div_rsp,
  input  logic [arc_pkg::VALUE_BITS-1:0] quotient
);
  import arc_pkg::*;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] work_r, work_nxt;
  logic [DIG_AW:0]       cnt_r, cnt_nxt;
  logic [DIG_AW-1:0]     idx_r, idx_nxt;
  logic [3:0]            rd_data_r;

  logic [3:0]            digit_mem [MAX_DIGITS];

  logic [3:0]            digit_val;
  logic                  digit_ok;
  logic                  letters_ok;
  logic [VALUE_BITS-1:0] scaled;
  logic [VALUE_BITS-1:0] acc_step;
  logic                  mem_we;
  logic [DIG_AW-1:0]     rd_addr;
  logic [7:0]            ch_ofs;

  // Character decode: letters count only for a non-decimal source.
  assign letters_ok = (cfg.source_base != BASE_DEC);

  always_comb begin
    digit_ok  = 1'b1;
    digit_val = 4'd0;
    if (in_char_code >= 8'd48 && in_char_code <= 8'd57) begin
      digit_val = 4'(in_char_code - DIGIT_OFFSET);
    end else if (letters_ok && in_char_code >= 8'd65 && in_char_code <= 8'd70) begin
      digit_val = 4'(in_char_code - LETTER_UPPER_OFFSET);
    end else if (letters_ok && in_char_code >= 8'd97 && in_char_code <= 8'd102) begin
      digit_val = 4'(in_char_code - LETTER_LOWER_OFFSET);
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    case (cfg.source_base)
      BASE_BIN: scaled = acc_r << 1;
      BASE_OCT: scaled = acc_r << 3;
      BASE_DEC: scaled = (acc_r << 3) + (acc_r << 1);
      BASE_HEX: scaled = acc_r << 4;
      default:  scaled = acc_r << 4;
    endcase
  end

  assign acc_step = scaled + VALUE_BITS'(digit_val);

  always_comb begin
    state_nxt         = state_r;
    acc_nxt           = acc_r;
    work_nxt          = work_r;
    cnt_nxt           = cnt_r;
    idx_nxt           = idx_r;
    div_req.start     = 1'b0;
    div_req.radix_sel = cfg.target_base;
    mem_we            = 1'b0;
    rd_addr           = idx_r;
    out_valid         = 1'b0;
    out_digit_last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (digit_ok) begin
            acc_nxt = acc_step;
          end
          if (in_is_final) begin
            work_nxt  = digit_ok ? acc_step : acc_r;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          mem_we   = 1'b1;
          work_nxt = quotient;
          cnt_nxt  = cnt_r + 1'b1;
          // Digits come out least significant first; stop on a zero
          // quotient or when the store is full.
          if (quotient == '0 || cnt_r == (DIG_AW + 1)'(MAX_DIGITS - 1)) begin
            idx_nxt   = cnt_r[DIG_AW-1:0];
            state_nxt = ST_EMIT_LOAD;
          end else begin
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_EMIT_LOAD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid      = 1'b1;
        out_digit_last = (idx_r == '0);
        rd_addr        = idx_r - 1'b1;
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[DIG_AW-1:0]] <= div_rsp.remainder;
    end
    rd_data_r <= digit_mem[rd_addr];
  end

  assign ch_ofs         = (rd_data_r < 4'd10) ? DIGIT_OFFSET : LETTER_UPPER_OFFSET;
  assign out_digit_char = {4'd0, rd_data_r} + ch_ofs;
  assign dividend       = work_r;
  assign busy           = (state_r != ST_IDLE);

endmodule

// ===== sv/ascii_radix_converter.sv =====
// ASCII radix converter.
// Characters of a number arrive on the command channel, most significant
// first: a transaction is taken at a clock edge with start high and busy low.
// Each digit character is folded into a 32-bit accumulator in that cycle, so
// non-final characters are taken back to back, one per cycle.
// The character flagged in_is_final starts the conversion and raises busy.
// The value is split into target-base digits by one shared restoring divider
// that yields one quotient bit per cycle. The digits are then read back from
// a small store, one per cycle, on out_valid with out_digit_char, and
// out_digit_last on the final one. out_valid is a one-cycle strobe: the
// receiver cannot hold results off. source_base and target_base sit on the
// APB port at offsets 0 and 4; the user must see that they are written only
// while busy is low, as the block itself does not enforce it. Reset clears
// the accumulator and sets the bases to binary in and decimal out.
module ascii_radix_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_char_code,
  input  logic        in_is_final,
  output logic        out_valid,
  output logic [7:0]  out_digit_char,
  output logic        out_digit_last
);
  import arc_pkg::*;

  cfg_t                  cfg;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [VALUE_BITS-1:0] dividend;
  logic [VALUE_BITS-1:0] quotient;

  arc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (dividend),
    .rsp      (div_rsp),
    .quotient (quotient)
  );

  arc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .start          (start),
    .in_char_code   (in_char_code),
    .in_is_final    (in_is_final),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_digit_last (out_digit_last),
    .div_req        (div_req),
    .dividend       (dividend),
    .div_rsp        (div_rsp),
    .quotient       (quotient)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_strobe_busy, out_valid |-> busy, "digit strobe while idle")
  `ASSERT_NEXT(a_char_no_busy, start && !busy && !in_is_final, !busy, "busy after plain char")
  `ASSERT_NEXT(a_final_busy, start && !busy && in_is_final, busy, "final char did not start run")
  `ASSERT_NEXT(a_last_idle, out_valid && out_digit_last, !busy, "still busy after last digit")
  `ASSERT_CLK(a_div_in_run, div_rsp.done |-> (busy && !out_valid), "divider done outside split")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import arc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_LIMIT   = 8000;
  localparam int RANDOM_ITEMS = 250;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } digit_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [7:0]  in_char_code;
  logic        in_is_final;
  logic        out_valid;
  logic [7:0]  out_digit_char;
  logic        out_digit_last;

  // Predictor state: the bases as last written, the running value and the expected digits.
  base_t                 src_base;
  base_t                 tgt_base;
  logic [VALUE_BITS-1:0] accum;
  digit_t                expected_digits[$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int          burst_left     = 0;

  ascii_radix_converter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_is_final    (in_is_final),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_digit_last (out_digit_last)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int unsigned radix_value(base_t b);
    case (b)
      BASE_BIN: return 2;
      BASE_OCT: return 8;
      BASE_DEC: return 10;
      default:  return 16;
    endcase
  endfunction

  // Letters count as digits only when the source is not decimal.
  function automatic bit digit_of(input logic [7:0] c, input base_t src, output logic [3:0] d);
    d = '0;
    if (c >= "0" && c <= "9") begin
      d = 4'(c - DIGIT_OFFSET);
      return 1'b1;
    end
    if (src != BASE_DEC && c >= "A" && c <= "F") begin
      d = 4'(c - LETTER_UPPER_OFFSET);
      return 1'b1;
    end
    if (src != BASE_DEC && c >= "a" && c <= "f") begin
      d = 4'(c - LETTER_LOWER_OFFSET);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_char(input logic [7:0] c, input logic fin);
    logic [3:0]            d;
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] r;
    logic [3:0]            ds[MAX_DIGITS];
    int                    n;
    digit_t                e;
    bit                    ok;
    ok = digit_of(c, src_base, d);
    if (ok) begin
      accum = accum * radix_value(src_base) + VALUE_BITS'(d);
    end
    if (!fin) begin
      return;
    end
    r = radix_value(tgt_base);
    v = accum;
    n = 0;
    // Zero still yields one digit, so the loop body runs at least once.
    do begin
      ds[n] = 4'(v % r);
      v = v / r;
      n++;
    end while (v != 0 && n < MAX_DIGITS);
    for (int k = 0; k < n; k++) begin
      e.ch = (ds[n-1-k] < 10) ? DIGIT_OFFSET + 8'(ds[n-1-k])
                              : LETTER_UPPER_OFFSET + 8'(ds[n-1-k]);
      e.last = (k == n - 1);
      expected_digits = {expected_digits, e};
    end
    accum = '0;
  endfunction

  function automatic logic [7:0] random_digit_char(base_t b);
    logic [3:0]  d;
    int unsigned top;
    top = radix_value(b) - 1;
    // Now and then a digit at or above the radix of a non-decimal source, which still counts.
    if ($urandom_range(0, 9) == 0) begin
      top = (b == BASE_DEC) ? 9 : 15;
    end
    d = 4'($urandom_range(0, top));
    if (d < 10) begin
      return DIGIT_OFFSET + 8'(d);
    end
    return ($urandom_range(0, 1) != 0) ? LETTER_UPPER_OFFSET + 8'(d)
                                       : LETTER_LOWER_OFFSET + 8'(d);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: %s", $time, msg);
  endtask

  // Pauses the sender until every expected digit has come and busy is low.
  task automatic drain_results();
    start <= 1'b0;
    while (expected_digits.size() != 0) begin
      @(posedge clk);
    end
    do @(posedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic write_base(input reg_idx_t idx, input base_t b);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {30'($urandom), b};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_SOURCE_BASE: src_base = b;
      default:         tgt_base = b;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_char(input logic [7:0] c, input logic fin);
    int unsigned gap;
    if (burst_left <= 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    start        <= 1'b1;
    in_char_code <= c;
    in_is_final  <= fin;
    do @(posedge clk); while (busy);
    predict_char(c, fin);
    burst_left--;
  endtask

  task automatic send_number(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic test_reset_defaults();
    send_number("101");
  endtask

  task automatic test_max_digits();
    write_base(REG_SOURCE_BASE, BASE_HEX);
    write_base(REG_TARGET_BASE, BASE_BIN);
    send_number("FFFFffff");
  endtask

  task automatic test_ignored_codes();
    write_base(REG_SOURCE_BASE, BASE_BIN);
    write_base(REG_TARGET_BASE, BASE_HEX);
    send_char("F", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_decimal_source();
    write_base(REG_SOURCE_BASE, BASE_DEC);
    write_base(REG_TARGET_BASE, BASE_OCT);
    send_number("a-9");
  endtask

  task automatic test_same_base();
    write_base(REG_SOURCE_BASE, BASE_HEX);
    write_base(REG_TARGET_BASE, BASE_HEX);
    send_number("00a");
  endtask

  task automatic test_zero_value();
    write_base(REG_TARGET_BASE, BASE_DEC);
    send_number("0");
    send_number("x");
  endtask

  task automatic test_base_change_midnumber();
    write_base(REG_SOURCE_BASE, BASE_DEC);
    send_char("1", 1'b0);
    send_char("2", 1'b0);
    write_base(REG_SOURCE_BASE, BASE_HEX);
    send_char("3", 1'b1);
  endtask

  task automatic test_random();
    int unsigned counted;
    int unsigned len;
    logic [7:0]  c;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        write_base(reg_idx_t'($urandom_range(0, 1)), base_t'($urandom_range(0, 3)));
      end else if ($urandom_range(0, 14) == 0) begin
        drain_results();
      end
      // Long numbers can make the value wrap.
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (len > 2 && i == len / 2 && $urandom_range(0, 9) == 0) begin
          write_base(REG_SOURCE_BASE, base_t'($urandom_range(0, 3)));
        end
        c = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                        : random_digit_char(src_base);
        counted++;
        send_char(c, i == len - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    digit_t want;
    if (rst_n && out_valid) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit char=%h last=%b",
                                  out_digit_char, out_digit_last));
      end else begin
        want = expected_digits.pop_front();
        if (out_digit_char !== want.ch) begin
          report_mismatch($sformatf("digit_char: expected %h, got %h", want.ch, out_digit_char));
        end
        if (out_digit_last !== want.last) begin
          report_mismatch($sformatf("digit_last: expected %b, got %b",
                                    want.last, out_digit_last));
        end
      end
    end
  end

  // Counts cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    start        = 1'b0;
    in_char_code = '0;
    in_is_final  = 1'b0;
    src_base     = BASE_BIN;
    tgt_base     = BASE_DEC;
    accum        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_max_digits();
    test_ignored_codes();
    test_decimal_source();
    test_same_base();
    test_zero_value();
    test_base_change_midnumber();
    test_random();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_digits.size() != 0) begin
      report_mismatch($sformatf("%0d digits never came", expected_digits.size()));
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
